### rtl/core/ufsq_pkg.sv
`default_nettype none

package ufsq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_URGENT = 2'd2;

  typedef struct packed {
    logic [15:0] requester;
    logic [15:0] group;
    logic [7:0]  minutes;
    logic        urgent;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef struct packed {
    logic take;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             pop_pending;
  } stat_t;

endpackage

`default_nettype wire

### rtl/core/urgent_front_service_queue_unit.sv
// Each accepted request is followed by an update state that uses the registered
// read of the waiting store; its result is registered there. A new request is
// taken only back in the idle state, and not while a result is stalled at the output.
// Reset (synchronous, active low) clears the front pointer, entry count,
// the job in service and the handshake state; the waiting store is not cleared.
`default_nettype none

module urgent_front_service_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_requester_id,
  input  wire logic [15:0] in_group_id,
  input  wire logic [7:0]  in_minutes_needed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_serving,
  output logic             out_urgent_job,
  output logic [15:0]      out_served_requester,
  output logic [15:0]      out_served_group,
  output logic [7:0]       out_time_left,
  output logic             out_dropped
);

  import ufsq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ufsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ufsq_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_mode              (in_mode),
    .in_requester_id      (in_requester_id),
    .in_group_id          (in_group_id),
    .in_minutes_needed    (in_minutes_needed),
    .out_serving          (out_serving),
    .out_urgent_job       (out_urgent_job),
    .out_served_requester (out_served_requester),
    .out_served_group     (out_served_group),
    .out_time_left        (out_time_left),
    .out_dropped          (out_dropped),
    .stat                 (stat)
  );

`ifndef SYNTHESIS
  a_take_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> cmd.update && !cmd.take)
    else $error("accepted request not followed by an update cycle");

  a_update_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid)
    else $error("update cycle did not present a result");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update && stat.pop_pending |-> stat.count != '0)
    else $error("pop pending with an empty queue");
`endif

endmodule

`default_nettype wire

### rtl/core/ufsq_ram.sv
`default_nettype none

module ufsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/core/ufsq_ctrl.sv
`default_nettype none

module ufsq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ufsq_pkg::cmd_t     cmd
);

  import ufsq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_take;

  assign can_take   = (state_r == ST_IDLE) && (!out_valid_r || !out_stall);
  assign in_stall   = !can_take;
  assign out_valid  = out_valid_r;
  assign cmd.take   = can_take && in_valid;
  assign cmd.update = (state_r == ST_UPDATE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.take) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ufsq_dpath.sv
`default_nettype none

module ufsq_dpath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ufsq_pkg::cmd_t cmd,
  input  wire logic [1:0]    in_mode,
  input  wire logic [15:0]   in_requester_id,
  input  wire logic [15:0]   in_group_id,
  input  wire logic [7:0]    in_minutes_needed,
  output logic               out_serving,
  output logic               out_urgent_job,
  output logic [15:0]        out_served_requester,
  output logic [15:0]        out_served_group,
  output logic [7:0]         out_time_left,
  output logic               out_dropped,
  output ufsq_pkg::stat_t    stat
);

  import ufsq_pkg::*;

  logic [IDX_W-1:0] front_r;
  logic [CNT_W-1:0] count_r;
  job_t             cur_r;
  job_t             req_r;
  logic             fwd_r;
  logic             pop_r;
  logic             dropped_r;

  logic             is_req;
  logic             is_urgent;
  logic             full;
  logic             push;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [SUM_W-1:0] back_sum;
  logic [IDX_W-1:0] back_idx;
  logic [CNT_W-1:0] count_after;
  logic [IDX_W-1:0] wr_addr;
  job_t             req;
  job_t             rd_job;
  logic [JOB_W-1:0] rd_word;
  job_t             popped;
  job_t             cur_upd;

  assign is_req    = (in_mode == MODE_NORMAL) || (in_mode == MODE_URGENT);
  assign is_urgent = (in_mode == MODE_URGENT);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign push      = is_req && !full;

  assign front_dec = (front_r == '0) ? IDX_W'(QUEUE_DEPTH - 1) : front_r - IDX_W'(1);
  assign front_inc = (front_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : front_r + IDX_W'(1);
  assign back_sum  = SUM_W'(front_r) + SUM_W'(count_r);
  assign back_idx  = (back_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     IDX_W'(back_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(back_sum);
  assign count_after = count_r + CNT_W'(push);
  assign wr_addr   = is_urgent ? front_dec : back_idx;

  always_comb begin
    req.requester = in_requester_id;
    req.group     = in_group_id;
    req.minutes   = in_minutes_needed;
    req.urgent    = is_urgent;
  end

  // The front entry is read in the request cycle. When the request itself
  // becomes the front entry, it is taken from the holding register instead.
  ufsq_ram #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.take && push),
    .wr_addr (wr_addr),
    .wr_data (req),
    .rd_addr (front_r),
    .rd_data (rd_word)
  );

  assign rd_job  = job_t'(rd_word);
  assign popped  = fwd_r ? req_r : rd_job;
  assign cur_upd = pop_r ? popped : cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r   <= '0;
      count_r   <= '0;
      cur_r     <= '0;
      fwd_r     <= 1'b0;
      pop_r     <= 1'b0;
      dropped_r <= 1'b0;
    end else if (cmd.take) begin
      front_r   <= (push && is_urgent) ? front_dec : front_r;
      count_r   <= count_after;
      fwd_r     <= push && (is_urgent || (count_r == '0));
      pop_r     <= (cur_r.minutes < 8'd2) && (count_after != '0);
      dropped_r <= is_req && full;
      if (cur_r.minutes >= 8'd2) begin
        cur_r.minutes <= cur_r.minutes - 8'd1;
      end else if (count_after == '0) begin
        cur_r <= '0;
      end
    end else if (cmd.update && pop_r) begin
      cur_r   <= popped;
      front_r <= front_inc;
      count_r <= count_r - CNT_W'(1);
      pop_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_serving          <= (cur_upd.minutes != '0);
      out_urgent_job       <= (cur_upd.minutes != '0) && cur_upd.urgent;
      out_served_requester <= (cur_upd.minutes != '0) ? cur_upd.requester : '0;
      out_served_group     <= (cur_upd.minutes != '0) ? cur_upd.group : '0;
      out_time_left        <= cur_upd.minutes;
      out_dropped          <= dropped_r;
    end
    if (cmd.take) begin
      req_r <= req;
    end
  end

  assign stat.count       = count_r;
  assign stat.pop_pending = pop_r;

endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ufsq_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int PHASE_ITEMS = 584;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic        serving;
    logic        urgent;
    logic [15:0] requester;
    logic [15:0] group;
    logic [7:0]  left;
    logic        dropped;
  } service_res_t;

  typedef struct packed {
    logic         has;
    service_res_t res;
  } pin_t;

  typedef struct {
    logic [1:0]   mode;
    logic [15:0]  requester;
    logic [15:0]  group;
    logic [7:0]   minutes;
    int           reps;
    logic         pinned;
    service_res_t res;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_TICK;
  logic [15:0] in_requester_id = '0;
  logic [15:0] in_group_id = '0;
  logic [7:0]  in_minutes_needed = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_serving;
  logic        out_urgent_job;
  logic [15:0] out_served_requester;
  logic [15:0] out_served_group;
  logic [7:0]  out_time_left;
  logic        out_dropped;

  urgent_front_service_queue_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_requester_id      (in_requester_id),
    .in_group_id          (in_group_id),
    .in_minutes_needed    (in_minutes_needed),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_serving          (out_serving),
    .out_urgent_job       (out_urgent_job),
    .out_served_requester (out_served_requester),
    .out_served_group     (out_served_group),
    .out_time_left        (out_time_left),
    .out_dropped          (out_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  job_t         waiting [QUEUE_DEPTH];
  int           head_idx = 0;
  int           waiting_n = 0;
  job_t         in_service = '0;
  service_res_t due_results [$];
  pin_t         pinned_results [$];
  int           fault_count = 0;
  int           send_gap_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_asks = 0;
  int           hold_done = 0;
  int           hold_left = 0;
  plan_row_t    plan [$];

  // One queue tick: store or drop the request, then age or replace the job in service.
  function automatic service_res_t serve_tick(input logic [1:0] mode, input logic [15:0] req,
                                              input logic [15:0] grp, input logic [7:0] mins);
    job_t         fresh;
    service_res_t r;
    fresh.requester = req;
    fresh.group = grp;
    fresh.minutes = mins;
    fresh.urgent = (mode == MODE_URGENT);
    r.dropped = 1'b0;
    if (mode == MODE_NORMAL || mode == MODE_URGENT) begin
      if (waiting_n >= QUEUE_DEPTH) begin
        r.dropped = 1'b1;
      end else if (mode == MODE_URGENT) begin
        head_idx = (head_idx + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
        waiting[head_idx] = fresh;
        waiting_n++;
      end else begin
        waiting[(head_idx + waiting_n) % QUEUE_DEPTH] = fresh;
        waiting_n++;
      end
    end
    if (in_service.minutes >= 8'd2) begin
      in_service.minutes = in_service.minutes - 8'd1;
    end else if (waiting_n == 0) begin
      in_service = '0;
    end else begin
      in_service = waiting[head_idx];
      head_idx = (head_idx + 1) % QUEUE_DEPTH;
      waiting_n--;
    end
    r.serving = (in_service.minutes != 8'd0);
    r.urgent = r.serving ? in_service.urgent : 1'b0;
    r.requester = r.serving ? in_service.requester : 16'h0000;
    r.group = r.serving ? in_service.group : 16'h0000;
    r.left = in_service.minutes;
    return r;
  endfunction

  task automatic note_fault(input string what, input service_res_t want, input service_res_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t: %s: expected serving=%0b urgent=%0b requester=%h group=%h left=%0d dropped=%0b,",
               $realtime, what, want.serving, want.urgent, want.requester, want.group,
               want.left, want.dropped);
      $display("    got serving=%0b urgent=%0b requester=%h group=%h left=%0d dropped=%0b",
               got.serving, got.urgent, got.requester, got.group, got.left, got.dropped);
    end
  endtask

  always @(posedge clk) begin
    service_res_t want;
    service_res_t got;
    pin_t         pin;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got.serving = out_serving;
        got.urgent = out_urgent_job;
        got.requester = out_served_requester;
        got.group = out_served_group;
        got.left = out_time_left;
        got.dropped = out_dropped;
        if (due_results.size() == 0) begin
          note_fault("result with nothing outstanding", '0, got);
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (got.serving !== want.serving || got.urgent !== want.urgent ||
              got.requester !== want.requester || got.group !== want.group ||
              got.left !== want.left || got.dropped !== want.dropped) begin
            note_fault("wrong result", want, got);
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        want = serve_tick(in_mode, in_requester_id, in_group_id, in_minutes_needed);
        pin = pinned_results[0];
        pinned_results.delete(0);
        if (pin.has) begin
          want = pin.res;
        end
        due_results.insert(due_results.size(), want);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic offer(input logic [1:0] mode, input logic [15:0] req, input logic [15:0] grp,
                       input logic [7:0] mins, input logic has, input service_res_t res);
    pin_t pin;
    int   gap;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    pin.has = has;
    pin.res = res;
    pinned_results.insert(pinned_results.size(), pin);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_requester_id <= req;
    in_group_id <= grp;
    in_minutes_needed <= mins;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic wait_all_served();
    in_valid <= 1'b0;
    while (due_results.size() != 0 || pinned_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_ticks(input int count);
    int          req_pct;
    int          pick;
    logic [1:0]  mode;
    logic [7:0]  mins;
    req_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        req_pct = $urandom_range(20, 90);
      end
      pick = $urandom_range(99);
      if (pick < req_pct) begin
        mode = ($urandom_range(99) < 30) ? MODE_URGENT : MODE_NORMAL;
      end else begin
        mode = ($urandom_range(9) == 0) ? MODE_SPARE : MODE_TICK;
      end
      if ($urandom_range(999) < 5) begin
        mins = 8'($urandom_range(0, 255));
      end else if ($urandom_range(99) < 15) begin
        mins = 8'($urandom_range(0, 31));
      end else begin
        mins = 8'($urandom_range(0, 3));
      end
      offer(mode, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), mins,
            1'b0, '0);
      if (hold_asks == 0 && send_gap_pct == 0 && recv_stall_pct == 0 && i == 100) begin
        hold_asks = 1;
      end
    end
  endtask

  initial begin
    plan.insert(plan.size(), '{MODE_TICK,   16'h0000, 16'h0000, 8'h00, 1, 1'b1, '0});
    plan.insert(plan.size(), '{MODE_URGENT, 16'hFFFF, 16'hFFFF, 8'h02, 1, 1'b1,
                               '{1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'd2, 1'b0}});
    plan.insert(plan.size(), '{MODE_NORMAL, 16'h0000, 16'h0000, 8'h00, 1, 1'b0, '0});
    plan.insert(plan.size(), '{MODE_SPARE,  16'hAAAA, 16'h5555, 8'hFF, 1, 1'b0, '0});
    plan.insert(plan.size(), '{MODE_TICK,   16'h5555, 16'hAAAA, 8'h7F, 1, 1'b1, '0});
    plan.insert(plan.size(), '{MODE_NORMAL, 16'h1234, 16'h5678, 8'hFF, 1, 1'b0, '0});
    plan.insert(plan.size(), '{MODE_NORMAL, 16'h00FF, 16'hFF00, 8'h01, 15, 1'b0, '0});
    plan.insert(plan.size(), '{MODE_URGENT, 16'h8001, 16'h0001, 8'h03, 1, 1'b0, '0});
    plan.insert(plan.size(), '{MODE_NORMAL, 16'h7FFF, 16'h7FFF, 8'h80, 1, 1'b0, '0});
    plan.insert(plan.size(), '{MODE_URGENT, 16'hFFFF, 16'h0000, 8'hFF, 1, 1'b0, '0});
    plan.insert(plan.size(), '{MODE_TICK,   16'h0000, 16'h0000, 8'h00, 4, 1'b0, '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 12;
    recv_stall_pct = 68;
    foreach (plan[i]) begin
      repeat (plan[i].reps) begin
        offer(plan[i].mode, plan[i].requester, plan[i].group, plan[i].minutes,
              plan[i].pinned, plan[i].res);
      end
    end
    random_ticks(PHASE_ITEMS);
    wait_all_served();

    send_gap_pct = 68;
    recv_stall_pct = 12;
    random_ticks(PHASE_ITEMS);
    wait_all_served();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    random_ticks(PHASE_ITEMS);
    wait_all_served();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && due_results.size() == 0) begin
      $display("urgent_front_service_queue_unit: match");
    end else begin
      $display("urgent_front_service_queue_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("urgent_front_service_queue_unit: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

### urgent_front_service_queue_unit.f
rtl/core/ufsq_pkg.sv
rtl/core/ufsq_ram.sv
rtl/core/ufsq_ctrl.sv
rtl/core/ufsq_dpath.sv
rtl/core/urgent_front_service_queue_unit.sv
tb/testbench.sv
